// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property forms for the list engine checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ALE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ale: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define ALE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ale: next-cycle check failed");

`endif

// File: rtl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// types and codes shared by the ordered list engine, its cells and checker
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int DATA_W = 32;
    localparam int OPC_W  = 3;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;
    localparam int OUT_W  = 8;

    // request opcodes; the two unused codes fall to the default arm
    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_LOCATE = 3'd3,
        OP_REMOVE = 3'd4,
        OP_READ   = 3'd5
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOCATE,
        S_REMOVE,
        S_READ
    } t_state;

    // operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_MARK,
        CELL_SCAN,
        CELL_COMPACT,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  key;
        logic [POS_W-1:0]          pos_idx;
        logic                      phase;
    } t_cell_cmd;

endpackage

// File: rtl/ale_cell.sv
// ----------------------------------------------------------------------------
// ale_cell
// one list entry with its match and hole flags, linked to both neighbors
// ----------------------------------------------------------------------------
module ale_cell #(
    parameter int CAPACITY = 128,
    parameter int INDEX    = 0
) (
    input  logic                                i_clk,
    input  ale_pkg::t_cell_cmd                  i_cmd,
    input  logic [$clog2(CAPACITY+1)-1:0]       i_count,
    input  logic signed [ale_pkg::DATA_W-1:0]   i_left_data,
    input  logic                                i_left_hole,
    input  logic signed [ale_pkg::DATA_W-1:0]   i_right_data,
    input  logic                                i_right_hole,
    input  logic                                i_right_scan,
    output logic signed [ale_pkg::DATA_W-1:0]   o_data,
    output logic                                o_scan,
    output logic                                o_hole
);
    import ale_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);
    localparam logic IDX_ODD = 1'(INDEX % 2);

    logic signed [DATA_W-1:0] r_data, n_data;
    logic                     r_scan, n_scan;
    logic                     r_hole, n_hole;
    logic [CMP_W-1:0]         pos_x;
    logic                     in_list;
    logic                     key_hit;
    logic                     pair_left;

    assign pos_x     = CMP_W'(i_cmd.pos_idx);
    assign in_list   = MY_IDX < CMP_W'(i_count);
    assign key_hit   = (r_data == i_cmd.key);
    // left member of an odd-even pair when parity matches the phase
    assign pair_left = (IDX_ODD == i_cmd.phase);

    always_comb begin
        n_data = r_data;
        n_scan = r_scan;
        n_hole = r_hole;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (MY_IDX == pos_x) begin
                    n_data = i_cmd.key;
                end else if (MY_IDX > pos_x) begin
                    n_data = i_left_data;
                end
            end
            CELL_DELETE: begin
                if (MY_IDX >= pos_x) begin
                    n_data = i_right_data;
                end
            end
            CELL_MARK: begin
                n_scan = in_list && key_hit;
                n_hole = !in_list || key_hit;
            end
            CELL_SCAN: begin
                n_scan = i_right_scan;
            end
            CELL_COMPACT: begin
                n_scan = i_right_scan;
                // holes drift right past kept entries, order of kept ones stays
                if (pair_left) begin
                    if (r_hole && !i_right_hole) begin
                        n_data = i_right_data;
                        n_hole = 1'b0;
                    end
                end else begin
                    if (i_left_hole && !r_hole) begin
                        n_data = i_left_data;
                        n_hole = 1'b1;
                    end
                end
            end
            CELL_ROTATE: begin
                n_data = i_right_data;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_scan <= n_scan;
        r_hole <= n_hole;
    end

    assign o_data = r_data;
    assign o_scan = r_scan;
    assign o_hole = r_hole;

endmodule

// File: rtl/array_list_engine.sv
// clear, insert, delete, a bad position and an unused code finish in the decode state;
// locate scans until the first match reaches cell 0 or the whole list has passed by
// remove all matches compacts over the whole list; read makes one full turn of the cell ring
// a new request is taken only once the current one has shown its strobe; the scan
// of the chain moves one cell per cycle; the receiver cannot stall
// reset clears the element count and control; entries are left as they are
// ----------------------------------------------------------------------------
// array_list_engine
// ordered list of signed 32-bit values held in a chain of cells
// ----------------------------------------------------------------------------
module array_list_engine #(
    parameter int CAPACITY = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ale_pkg::OPC_W-1:0]           i_opcode,
    input  logic [ale_pkg::POS_W-1:0]           i_position,
    input  logic signed [ale_pkg::DATA_W-1:0]   i_value,
    output logic                                o_valid,
    output logic [ale_pkg::STAT_W-1:0]          o_status,
    output logic                                o_found,
    output logic [ale_pkg::OUT_W-1:0]           o_found_position,
    output logic signed [ale_pkg::DATA_W-1:0]   o_read_value,
    output logic [ale_pkg::OUT_W-1:0]           o_removed_count,
    output logic [ale_pkg::OUT_W-1:0]           o_element_total
);
    import ale_pkg::*;

    // count holds 0..CAPACITY; compares run one bit wider so count + 1 fits
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // request and control state
    t_state                   r_state, n_state;
    t_opcode                  r_op, n_op;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_step, n_step;
    logic [CNT_W-1:0]         r_removed, n_removed;
    logic signed [DATA_W-1:0] r_rval, n_rval;

    // result registers, the strobe marks the single cycle a result is shown
    logic                     r_valid, n_valid;
    t_status                  r_status, n_status;
    logic                     r_found, n_found;
    logic [OUT_W-1:0]         r_fpos, n_fpos;
    logic signed [DATA_W-1:0] r_out_rval, n_out_rval;
    logic [OUT_W-1:0]         r_out_removed, n_out_removed;
    logic [OUT_W-1:0]         r_total, n_total;

    // cell chain
    t_cell_cmd                cell_cmd;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]      cell_scan;
    logic [CAPACITY-1:0]      cell_hole;
    logic signed [DATA_W-1:0] head_data;
    logic                     head_scan;

    // widened views for range checks
    logic [CMP_W-1:0]         count_x;
    logic [CMP_W-1:0]         pos_x;
    logic [CMP_W-1:0]         step_x;
    logic                     pos_zero;
    logic signed [DATA_W-1:0] read_sel;

    assign count_x   = CMP_W'(r_count);
    assign pos_x     = CMP_W'(r_pos);
    assign step_x    = CMP_W'(r_step);
    assign pos_zero  = (r_pos == '0);
    assign head_data = cell_data[0];
    assign head_scan = cell_scan[0];

    // during a read the ring turns once; the wanted entry passes cell 0
    assign read_sel = (step_x == pos_x - CMP_W'(1)) ? head_data : r_rval;

    // ------------------------------------------------------------------------
    // state register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_valid   <= n_valid;
        end
    end

    // request and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_pos         <= n_pos;
        r_val         <= n_val;
        r_step        <= n_step;
        r_removed     <= n_removed;
        r_rval        <= n_rval;
        r_status      <= n_status;
        r_found       <= n_found;
        r_fpos        <= n_fpos;
        r_out_rval    <= n_out_rval;
        r_out_removed <= n_out_removed;
        r_total       <= n_total;
    end

    // ------------------------------------------------------------------------
    // next state, cell command and results
    // ------------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_pos         = r_pos;
        n_val         = r_val;
        n_count       = r_count;
        n_step        = r_step;
        n_removed     = r_removed;
        n_rval        = r_rval;
        n_valid       = 1'b0;
        n_status      = ST_OK;
        n_found       = 1'b0;
        n_fpos        = '0;
        n_out_rval    = '0;
        n_out_removed = '0;

        cell_cmd.op      = CELL_HOLD;
        cell_cmd.key     = r_val;
        cell_cmd.pos_idx = r_pos - POS_W'(1);
        cell_cmd.phase   = r_step[0];

        case (r_state)
            S_IDLE: begin
                // capture the transaction
                if (start) begin
                    n_op    = t_opcode'(i_opcode);
                    n_pos   = i_position;
                    n_val   = i_value;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                case (r_op)
                    OP_CLEAR: begin
                        n_count = '0;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_INSERT: begin
                        // full check wins over the position check
                        if (count_x >= CMP_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else if (pos_zero || pos_x > count_x + CMP_W'(1)) begin
                            n_status = ST_RANGE;
                        end else begin
                            cell_cmd.op = CELL_INSERT;
                            n_count     = r_count + CNT_W'(1);
                        end
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_DELETE: begin
                        if (pos_zero || pos_x > count_x) begin
                            n_status = ST_RANGE;
                        end else begin
                            cell_cmd.op = CELL_DELETE;
                            n_count     = r_count - CNT_W'(1);
                        end
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_LOCATE: begin
                        cell_cmd.op = CELL_MARK;
                        n_step      = '0;
                        n_state     = S_LOCATE;
                    end
                    OP_REMOVE: begin
                        cell_cmd.op = CELL_MARK;
                        n_step      = '0;
                        n_removed   = '0;
                        n_state     = S_REMOVE;
                    end
                    OP_READ: begin
                        if (pos_zero || pos_x > count_x) begin
                            n_status = ST_RANGE;
                            n_valid  = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_step  = '0;
                            n_rval  = '0;
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        // unused codes leave the list alone
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_LOCATE: begin
                // match flags march toward cell 0, one position per cycle
                if (r_step == r_count) begin
                    n_fpos  = OUT_W'(count_x + CMP_W'(1));
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (head_scan) begin
                    n_found = 1'b1;
                    n_fpos  = OUT_W'(step_x + CMP_W'(1));
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    cell_cmd.op = CELL_SCAN;
                    n_step      = r_step + CNT_W'(1);
                end
            end

            S_REMOVE: begin
                // count phases of odd-even exchange settle the holes at the tail,
                // while the match flags shifting out of cell 0 are tallied
                if (r_step == r_count) begin
                    n_count       = r_count - r_removed;
                    n_out_removed = OUT_W'(r_removed);
                    n_valid       = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    cell_cmd.op = CELL_COMPACT;
                    n_removed   = r_removed + CNT_W'(head_scan);
                    n_step      = r_step + CNT_W'(1);
                end
            end

            S_READ: begin
                cell_cmd.op = CELL_ROTATE;
                n_rval      = read_sel;
                if (r_step == CNT_W'(CAPACITY - 1)) begin
                    // last turn brings the ring back to its original order
                    n_out_rval = read_sel;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_step = r_step + CNT_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_total = OUT_W'(n_count);
    end

    // ------------------------------------------------------------------------
    // the chain: cell 0 is list position 1, the right end wraps for rotation
    // ------------------------------------------------------------------------
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [DATA_W-1:0] left_data;
        logic                     left_hole;
        logic signed [DATA_W-1:0] right_data;
        logic                     right_hole;
        logic                     right_scan;

        if (gi == 0) begin : g_first
            assign left_data = '0;
            assign left_hole = 1'b0;
        end else begin : g_inner_left
            assign left_data = cell_data[gi-1];
            assign left_hole = cell_hole[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign right_data = cell_data[0];
            assign right_hole = 1'b1;
            assign right_scan = 1'b0;
        end else begin : g_inner_right
            assign right_data = cell_data[gi+1];
            assign right_hole = cell_hole[gi+1];
            assign right_scan = cell_scan[gi+1];
        end

        ale_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (gi)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cell_cmd),
            .i_count      (r_count),
            .i_left_data  (left_data),
            .i_left_hole  (left_hole),
            .i_right_data (right_data),
            .i_right_hole (right_hole),
            .i_right_scan (right_scan),
            .o_data       (cell_data[gi]),
            .o_scan       (cell_scan[gi]),
            .o_hole       (cell_hole[gi])
        );
    end

    // ------------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------------
    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_found          = r_found;
    assign o_found_position = r_fpos;
    assign o_read_value     = r_out_rval;
    assign o_removed_count  = r_out_removed;
    assign o_element_total  = r_total;

endmodule

// File: rtl/ale_checker.sv
// ----------------------------------------------------------------------------
// ale_checker
// port-level checks on the ordered list engine, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ale_checker #(
    parameter int CAPACITY = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic                        i_valid,
    input  logic [ale_pkg::STAT_W-1:0]  i_status,
    input  logic                        i_found,
    input  logic [ale_pkg::OUT_W-1:0]   i_element_total
);
    import ale_pkg::*;

    localparam logic [OUT_W-1:0] TOTAL_FULL = OUT_W'(CAPACITY);

    // an accepted transaction makes the engine busy in the next cycle
    `ALE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy)
    // a result is only shown once the engine is free again
    `ALE_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, i_valid, !i_busy)
    // a rejected insert means the list sits at capacity
    `ALE_ASSERT_IMPLY(a_full_total, i_clk, i_rst_n, i_valid && i_status == ST_FULL, i_element_total == TOTAL_FULL)
    // a hit only comes from a locate, which never flags an error
    `ALE_ASSERT_IMPLY(a_found_ok, i_clk, i_rst_n, i_valid && i_found, i_status == ST_OK)

endmodule

bind array_list_engine ale_checker #(
    .CAPACITY (CAPACITY)
) u_ale_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (start),
    .i_busy          (busy),
    .i_valid         (o_valid),
    .i_status        (o_status),
    .i_found         (o_found),
    .i_element_total (o_element_total)
);
